// File: src/clipped_box_mean_filter_macros.svh
// ----------------------------------------------------------------------------
// Clipped box mean filter assertion macros
// Shared assertion shorthands clocked on clk with asynchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_BOX_MEAN_FILTER_MACROS_SVH
`define CLIPPED_BOX_MEAN_FILTER_MACROS_SVH

// condition holds in the same cycle
`define CBMF_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// condition holds in the next cycle
`define CBMF_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: src/cbmf_pkg.sv
// ----------------------------------------------------------------------------
// Clipped box mean filter package
// Register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package cbmf_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 11;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [2:0]       RST_RADIUS       = 3'd1;
    localparam logic             RST_COLOR_MODE   = 1'b0;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_RADIUS,
        CFG_COLOR_MODE
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_WAIT,
        ST_DIVS,
        ST_DIVW,
        ST_OUT
    } state_t;

endpackage

// File: src/cbmf_ram.sv
// ----------------------------------------------------------------------------
// Clipped box mean filter RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module cbmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 15360
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/cbmf_div.sv
// ----------------------------------------------------------------------------
// Clipped box mean filter divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbmf_div #(
    parameter int SUMW = 16,
    parameter int CNTW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SUMW-1:0] dividend,
    input  logic [CNTW-1:0] divisor,
    output logic            busy,
    output logic            done,
    output logic [7:0]      quotient
);

    localparam int ITW = $clog2(SUMW + 1);

    logic [SUMW-1:0] dvd_reg, dvd_next;
    logic [SUMW-1:0] quo_reg, quo_next;
    logic [CNTW-1:0] rem_reg, rem_next;
    logic [ITW-1:0]  it_reg, it_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW:0]   trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[SUMW-1]};
        if (start)
        begin
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            it_next   = ITW'(SUMW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[SUMW-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = CNTW'(trial - {1'b0, divisor});
                quo_next = {quo_reg[SUMW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNTW-1:0];
                quo_next = {quo_reg[SUMW-2:0], 1'b0};
            end
            it_next = it_reg - 1'b1;
            if (it_reg == ITW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg[7:0];

endmodule

// File: src/clipped_box_mean_filter.sv
// An item with no result leaves the block ready for the next item.
// Each result runs SETUP, rows*cols window reads (one memory read a cycle), WAIT,
// then a divide per channel (one shared divider; 1 channel gray, 3 color) and OUT.
// Throughput: one item at a time; a burst of up to (MAX_RADIUS+1)^2 results per item.
// Reset: async active low; position clears, config registers take their default values.
// Line store memory has no clearing pass and no valid bits.
// ----------------------------------------------------------------------------
// Clipped box mean filter
// Raster stream box mean over a clipped square window, via line storage.
// ----------------------------------------------------------------------------
module clipped_box_mean_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_ch0, pixel_ch1, pixel_ch2
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // mean_ch0, mean_ch1, mean_ch2, out_row, out_col, pad
    output logic        m_tlast,   // run_last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_wdata
);

    import cbmf_pkg::*;

    localparam int WIN  = 2 * MAX_RADIUS + 1;
    localparam int SLW  = $clog2(WIN);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int DW   = $clog2(WIN + 1);
    localparam int CNTW = $clog2(WIN * WIN + 1);
    localparam int SUMW = $clog2(255 * WIN * WIN + 1);
    localparam int AW   = SLW + CW;
    localparam int DEPTH = WIN * (2 ** CW);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [2:0]       radius_reg;
    logic             color_mode_reg;

    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic [SLW-1:0] in_slot_reg, in_slot_next;

    logic [RW-1:0]  ir_reg, ir_next;
    logic [SLW-1:0] slot_ir_reg, slot_ir_next;
    logic [RW-1:0]  cur_r_reg, cur_r_next, r1_reg, r1_next;
    logic [CW-1:0]  cur_c_reg, cur_c_next, c0_reg, c0_next, c1_reg, c1_next;
    logic [RW-1:0]  y_reg, y_next, y1_reg, y1_next;
    logic [CW-1:0]  x_reg, x_next, x0_reg, x0_next, x1_reg, x1_next;
    logic [SLW-1:0] rslot_reg, rslot_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [SUMW-1:0] sum_reg [3];
    logic [SUMW-1:0] sum_next [3];
    logic [7:0]     mean_reg [3];
    logic [7:0]     mean_next [3];
    logic [1:0]     ch_reg, ch_next;
    logic           rd_vld_reg;

    logic [WW-1:0]  w;
    logic [HW-1:0]  h;
    logic [WW-1:0]  wm1;
    logic [HW-1:0]  hm1;
    logic [2:0]     rad;

    logic           col_wrap, row_wrap, end_row, row_end;
    logic [RW:0]    row_t, row_n;
    logic [CW:0]    col_n;
    logic [RW-1:0]  ir;
    logic [CW-1:0]  ic;
    logic [SLW-1:0] slot_t, slot_ir;
    logic [RW-1:0]  ir_lo;
    logic [CW-1:0]  ic_lo;
    logic           last_row, last_col, have_rows, have_cols;

    logic [RW-1:0]  y0, y1, row_dist;
    logic [CW-1:0]  x0, x1;
    logic [RW:0]    y_e;
    logic [CW:0]    x_e;
    logic [DW-1:0]  nrows, ncols;
    logic [SLW-1:0] slot_y;

    logic           accept;
    logic [AW-1:0]  waddr, raddr;
    logic [23:0]    rdata;
    logic           div_start, div_busy, div_done;
    logic [7:0]     div_q;
    logic [SUMW-1:0] div_dividend;
    logic [1:0]     last_ch;

    function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
        slot_inc = (s == SLW'(WIN - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb
    begin
        if (frame_width_reg == '0)
            w = WW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w = WW'(MAX_WIDTH);
        else
            w = WW'(frame_width_reg);
        if (frame_height_reg == '0)
            h = HW'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(frame_height_reg);
        rad = (32'(radius_reg) > MAX_RADIUS) ? 3'(MAX_RADIUS) : radius_reg;
        wm1 = w - 1'b1;
        hm1 = h - 1'b1;
    end

    assign accept = s_tvalid && s_tready;

    // position of this item, with wrap after a mid-frame size change
    always_comb
    begin
        col_wrap = in_col_reg >= w;
        row_t    = col_wrap ? {1'b0, in_row_reg} + 1'b1 : {1'b0, in_row_reg};
        row_wrap = row_t >= h;
        ir       = row_wrap ? '0 : row_t[RW-1:0];
        ic       = col_wrap ? '0 : in_col_reg;
        slot_t   = col_wrap ? slot_inc(in_slot_reg) : in_slot_reg;
        slot_ir  = row_wrap ? '0 : slot_t;
        col_n    = {1'b0, ic} + 1'b1;
        end_row  = col_n >= w;
        row_n    = {1'b0, ir} + 1'b1;
        row_end  = row_n >= h;
        ir_lo    = (ir >= RW'(rad)) ? ir - RW'(rad) : '0;
        ic_lo    = (ic >= CW'(rad)) ? ic - CW'(rad) : '0;
        last_row = ir == hm1;
        last_col = ic == wm1;
        have_rows = last_row || (ir >= RW'(rad));
        have_cols = last_col || (ic >= CW'(rad));
    end

    // clipped window of the current result
    always_comb
    begin
        y0    = (cur_r_reg >= RW'(rad)) ? cur_r_reg - RW'(rad) : '0;
        y_e   = {1'b0, cur_r_reg} + (RW + 1)'(rad);
        y1    = (y_e > hm1) ? RW'(hm1) : y_e[RW-1:0];
        x0    = (cur_c_reg >= CW'(rad)) ? cur_c_reg - CW'(rad) : '0;
        x_e   = {1'b0, cur_c_reg} + (CW + 1)'(rad);
        x1    = (x_e > wm1) ? CW'(wm1) : x_e[CW-1:0];
        nrows = DW'(y1 - y0 + 1'b1);
        ncols = DW'(x1 - x0 + 1'b1);
        row_dist = ir_reg - y0;
        slot_y = (slot_ir_reg >= SLW'(row_dist)) ? slot_ir_reg - SLW'(row_dist)
                                                  : slot_ir_reg + SLW'(WIN) - SLW'(row_dist);
    end

    assign last_ch      = color_mode_reg ? 2'd2 : 2'd0;
    assign div_start    = state_reg == ST_DIVS;
    assign div_dividend = sum_reg[ch_reg];

    always_comb
    begin
        state_next   = state_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_slot_next = in_slot_reg;
        ir_next      = ir_reg;
        slot_ir_next = slot_ir_reg;
        cur_r_next   = cur_r_reg;
        r1_next      = r1_reg;
        cur_c_next   = cur_c_reg;
        c0_next      = c0_reg;
        c1_next      = c1_reg;
        y_next       = y_reg;
        y1_next      = y1_reg;
        x_next       = x_reg;
        x0_next      = x0_reg;
        x1_next      = x1_reg;
        rslot_next   = rslot_reg;
        cnt_next     = cnt_reg;
        ch_next      = ch_reg;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i]  = sum_reg[i];
            mean_next[i] = mean_reg[i];
        end
        if (rd_vld_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_next[i] = sum_reg[i] + SUMW'(rdata[8*i +: 8]);
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_col_next  = end_row ? '0 : col_n[CW-1:0];
                    in_row_next  = end_row ? (row_end ? '0 : row_n[RW-1:0]) : ir;
                    in_slot_next = end_row ? (row_end ? '0 : slot_inc(slot_ir)) : slot_ir;
                    ir_next      = ir;
                    slot_ir_next = slot_ir;
                    cur_r_next   = ir_lo;
                    r1_next      = last_row ? ir : ir_lo;
                    cur_c_next   = ic_lo;
                    c0_next      = ic_lo;
                    c1_next      = last_col ? ic : ic_lo;
                    if (have_rows && have_cols)
                        state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                y_next     = y0;
                y1_next    = y1;
                x_next     = x0;
                x0_next    = x0;
                x1_next    = x1;
                rslot_next = slot_y;
                cnt_next   = CNTW'(nrows) * CNTW'(ncols);
                for (int i = 0; i < 3; i++)
                begin
                    sum_next[i] = '0;
                end
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (x_reg == x1_reg)
                begin
                    x_next     = x0_reg;
                    y_next     = y_reg + 1'b1;
                    rslot_next = slot_inc(rslot_reg);
                    if (y_reg == y1_reg)
                        state_next = ST_WAIT;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mean_next[i] = '0;
                end
                ch_next    = 2'd0;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    mean_next[ch_reg] = div_q;
                    if (ch_reg == last_ch)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (cur_c_reg == c1_reg)
                    begin
                        cur_c_next = c0_reg;
                        cur_r_next = cur_r_reg + 1'b1;
                        state_next = (cur_r_reg == r1_reg) ? ST_IDLE : ST_SETUP;
                    end
                    else
                    begin
                        cur_c_next = cur_c_reg + 1'b1;
                        state_next = ST_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            in_slot_reg      <= '0;
            rd_vld_reg       <= 1'b0;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            radius_reg       <= RST_RADIUS;
            color_mode_reg   <= RST_COLOR_MODE;
        end
        else
        begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_slot_reg <= in_slot_next;
            rd_vld_reg  <= state_reg == ST_READ;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                    CFG_RADIUS:       radius_reg       <= cfg_wdata[2:0];
                    CFG_COLOR_MODE:   color_mode_reg   <= cfg_wdata[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg      <= ir_next;
        slot_ir_reg <= slot_ir_next;
        cur_r_reg   <= cur_r_next;
        r1_reg      <= r1_next;
        cur_c_reg   <= cur_c_next;
        c0_reg      <= c0_next;
        c1_reg      <= c1_next;
        y_reg       <= y_next;
        y1_reg      <= y1_next;
        x_reg       <= x_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        rslot_reg   <= rslot_next;
        cnt_reg     <= cnt_next;
        ch_reg      <= ch_next;
        for (int i = 0; i < 3; i++)
        begin
            sum_reg[i]  <= sum_next[i];
            mean_reg[i] <= mean_next[i];
        end
    end

    assign waddr = {slot_ir, ic};
    assign raddr = {rslot_reg, x_reg};

    cbmf_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    cbmf_div #(
        .SUMW (SUMW),
        .CNTW (CNTW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = {4'b0, 10'(cur_c_reg), 10'(cur_r_reg),
                       mean_reg[2], mean_reg[1], mean_reg[0]};
    assign m_tlast  = (cur_r_reg == r1_reg) && (cur_c_reg == c1_reg);

`include "clipped_box_mean_filter_macros.svh"

    `CBMF_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
    `CBMF_ASSERT_NXT(a_busy_after_accept, accept && have_rows && have_cols, !s_tready)
    `CBMF_ASSERT_IMP(a_div_start_idle, div_start, !div_busy)
    `CBMF_ASSERT_IMP(a_gray_zero, m_tvalid && !color_mode_reg,
                     m_tdata[15:8] == 8'd0 && m_tdata[23:16] == 8'd0)
    `CBMF_ASSERT_IMP(a_read_window, rd_vld_reg,
                     state_reg == ST_READ || state_reg == ST_WAIT)

endmodule

// File: verif/tb_clipped_box_mean_filter.sv
// ----------------------------------------------------------------------------
// Clipped box mean filter testbench
// Streams whole frames under many frame, radius and color settings. Every
// accepted pixel updates a line-store predictor that queues the window means
// it releases. The monitor checks each result item against the oldest entry.
// ----------------------------------------------------------------------------
module tb_clipped_box_mean_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import cbmf_pkg::*;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 1024;
    localparam int MAXR       = 7;
    localparam int SLOTS      = 2 * MAXR + 1;
    localparam int SETTLE     = 4;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 3000;

    typedef enum logic [1:0] {K_PIXEL, K_WRITE, K_DRAIN} kind_t;

    typedef enum int {PAT_RANDOM, PAT_ONES, PAT_ZEROS, PAT_CHECKER} pattern_t;

    typedef struct {
        kind_t       kind;
        cfg_index_t  addr;
        logic [10:0] wdata;
        logic [23:0] pixel;
    } stim_t;

    typedef struct {
        logic [7:0] m0;
        logic [7:0] m1;
        logic [7:0] m2;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } mean_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_addr = CFG_FRAME_WIDTH;
    logic [10:0] cfg_wdata = '0;

    stim_t       pending_q[$];
    mean_t       mean_q[$];
    logic [23:0] line_mem [SLOTS][MAXW];
    logic [10:0] p_width = RST_FRAME_WIDTH;
    logic [10:0] p_height = RST_FRAME_HEIGHT;
    logic [2:0]  p_radius = RST_RADIUS;
    logic        p_color = RST_COLOR_MODE;
    int          pos_row = 0;
    int          pos_col = 0;
    int          err_cnt = 0;
    int          pix_total = 0;
    int          pix_acc = 0;
    int          settle_cnt = 0;
    int          send_idle = 10;
    int          recv_idle = 49;
    int          hold_cnt = 0;
    bit          hold_done = 0;
    int          idle_cyc = 0;

    clipped_box_mean_filter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int clamp_dim(input int v, input int maxv);
        if (v < 1)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    task automatic predict_means(input logic [23:0] px);
        int w, h, rad, ir, ic, r0, r1, c0, c1, y0, y1, x0, x1, cnt, s0, s1, s2;
        bit have_r, have_c;
        logic [23:0] p;
        mean_t e;
        w = clamp_dim(p_width, MAXW);
        h = clamp_dim(p_height, MAXH);
        rad = p_radius;
        have_r = 0;
        have_c = 0;
        r0 = 0; r1 = 0; c0 = 0; c1 = 0;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h)
            pos_row = 0;
        ir = pos_row;
        ic = pos_col;
        line_mem[ir % SLOTS][ic] = px;
        if (ir == h - 1)
        begin
            r0 = (ir >= rad) ? ir - rad : 0; r1 = ir; have_r = 1;
        end
        else if (ir >= rad)
        begin
            r0 = ir - rad; r1 = r0; have_r = 1;
        end
        if (ic == w - 1)
        begin
            c0 = (ic >= rad) ? ic - rad : 0; c1 = ic; have_c = 1;
        end
        else if (ic >= rad)
        begin
            c0 = ic - rad; c1 = c0; have_c = 1;
        end
        if (have_r && have_c)
        begin
            for (int r = r0; r <= r1; r++)
            begin
                for (int c = c0; c <= c1; c++)
                begin
                    y0 = (r >= rad) ? r - rad : 0;
                    y1 = (r + rad > h - 1) ? h - 1 : r + rad;
                    x0 = (c >= rad) ? c - rad : 0;
                    x1 = (c + rad > w - 1) ? w - 1 : c + rad;
                    s0 = 0; s1 = 0; s2 = 0;
                    for (int y = y0; y <= y1; y++)
                    begin
                        for (int x = x0; x <= x1; x++)
                        begin
                            p = line_mem[y % SLOTS][x];
                            s0 += p[7:0];
                            s1 += p[15:8];
                            s2 += p[23:16];
                        end
                    end
                    cnt = (y1 - y0 + 1) * (x1 - x0 + 1);
                    e.m0 = 8'(s0 / cnt);
                    e.m1 = p_color ? 8'(s1 / cnt) : 8'd0;
                    e.m2 = p_color ? 8'(s2 / cnt) : 8'd0;
                    e.row = 10'(r);
                    e.col = 10'(c);
                    e.last = (r == r1 && c == c1);
                    mean_q.push_back(e);
                end
            end
        end
        pos_col++;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h)
                pos_row = 0;
        end
    endtask

    task automatic add_write(input cfg_index_t a, input int v);
        stim_t s;
        s.kind = K_WRITE;
        s.addr = a;
        s.wdata = 11'(v);
        s.pixel = '0;
        pending_q.push_back(s);
    endtask

    task automatic add_frame(input int w, input int h, input int rad, input int color,
                             input pattern_t pattern);
        stim_t s;
        int n;
        add_write(CFG_FRAME_WIDTH, w);
        add_write(CFG_FRAME_HEIGHT, h);
        add_write(CFG_RADIUS, rad);
        add_write(CFG_COLOR_MODE, color);
        n = clamp_dim(w, MAXW) * clamp_dim(h, MAXH);
        for (int i = 0; i < n; i++)
        begin
            s.kind = K_PIXEL;
            s.addr = CFG_FRAME_WIDTH;
            s.wdata = '0;
            case (pattern)
                PAT_ONES:    s.pixel = 24'hFFFFFF;
                PAT_ZEROS:   s.pixel = 24'h000000;
                PAT_CHECKER: s.pixel = (i % 2) ? 24'hFFFFFF : 24'h000000;
                default:     s.pixel = 24'($urandom);
            endcase
            pending_q.push_back(s);
        end
        pix_total += n;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        bit    nv;
        bit    nwe;
        stim_t hd;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            cfg_we <= 1'b0;
        end
        else
        begin
            nv = s_tvalid;
            nwe = 1'b0;
            if (s_tvalid && s_tready)
            begin
                predict_means(s_tdata);
                pix_acc++;
                settle_cnt = 0;
                nv = 1'b0;
                if (pix_acc >= pix_total / 3)
                begin
                    send_idle = 49;
                    recv_idle = 10;
                end
                if (pix_acc >= 2 * pix_total / 3)
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            end
            if (!nv && pending_q.size() > 0)
            begin
                hd = pending_q[0];
                if (hd.kind == K_PIXEL)
                begin
                    if ($urandom_range(99) >= send_idle)
                    begin
                        void'(pending_q.pop_front());
                        s_tdata <= hd.pixel;
                        nv = 1'b1;
                    end
                end
                else if (mean_q.size() > 0)
                    settle_cnt = 0;
                else if (settle_cnt < SETTLE)
                    settle_cnt++;
                else
                begin
                    void'(pending_q.pop_front());
                    if (hd.kind == K_WRITE)
                    begin
                        nwe = 1'b1;
                        cfg_addr <= hd.addr;
                        cfg_wdata <= hd.wdata;
                        case (hd.addr)
                            CFG_FRAME_WIDTH:  p_width = hd.wdata;
                            CFG_FRAME_HEIGHT: p_height = hd.wdata;
                            CFG_RADIUS:       p_radius = hd.wdata[2:0];
                            default:          p_color = hd.wdata[0];
                        endcase
                    end
                end
            end
            s_tvalid <= nv;
            cfg_we <= nwe;
        end
    end

    // receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (!hold_done && pix_acc >= pix_total / 2)
        begin
            hold_done = 1;
            hold_cnt = HOLD_LEN;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor
    always @(posedge clk)
    begin
        mean_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mean_q.size() == 0)
            begin
                $error("unexpected result row %0d col %0d", m_tdata[33:24], m_tdata[43:34]);
                err_cnt++;
            end
            else
            begin
                e = mean_q.pop_front();
                if (m_tdata[7:0] !== e.m0)
                begin
                    $error("mean_ch0 exp %0d got %0d", e.m0, m_tdata[7:0]);
                    err_cnt++;
                end
                if (m_tdata[15:8] !== e.m1)
                begin
                    $error("mean_ch1 exp %0d got %0d", e.m1, m_tdata[15:8]);
                    err_cnt++;
                end
                if (m_tdata[23:16] !== e.m2)
                begin
                    $error("mean_ch2 exp %0d got %0d", e.m2, m_tdata[23:16]);
                    err_cnt++;
                end
                if (m_tdata[33:24] !== e.row)
                begin
                    $error("out_row exp %0d got %0d", e.row, m_tdata[33:24]);
                    err_cnt++;
                end
                if (m_tdata[43:34] !== e.col)
                begin
                    $error("out_col exp %0d got %0d", e.col, m_tdata[43:34]);
                    err_cnt++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("run_last exp %0d got %0d", e.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cyc = 0;
            else
                idle_cyc++;
            if (idle_cyc >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        stim_t s;
        int    w, h;
        add_frame(0, 0, 7, 1, PAT_ONES);
        add_frame(3, 2, 0, 0, PAT_RANDOM);
        add_frame(4, 3, 1, 1, PAT_ONES);
        add_frame(1, 5, 2, 1, PAT_CHECKER);
        add_frame(2, 1, 3, 1, PAT_ZEROS);
        s.kind = K_DRAIN;
        s.addr = CFG_FRAME_WIDTH;
        s.wdata = '0;
        s.pixel = '0;
        pending_q.push_back(s);
        while (pix_total < 380)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            add_frame(w, h, $urandom_range(0, 7), $urandom_range(0, 1),
                      ($urandom_range(9) == 0) ? pattern_t'($urandom_range(1, 3))
                                               : PAT_RANDOM);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() == 0 && mean_q.size() == 0 && !s_tvalid);
        repeat (400) @(posedge clk);
        if (err_cnt == 0 && mean_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
